// File: rtl/ddws_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the wheel setpoint block
package ddws_pkg;

    // field widths
    localparam int V_W       = 20;
    localparam int W_W       = 22;
    localparam int SPD_W     = 19;
    localparam int PPM_W     = 24;
    localparam int K_W       = 16;
    localparam int OSPD_W    = 22;
    localparam int RATE_W    = 32;
    localparam int DUTY_W    = 21;

    // internal widths
    localparam int WHL_W     = 25;
    localparam int MAG_W     = 24;
    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 24;
    localparam int PROD_W    = 51;
    localparam int DIV_W     = 46;
    localparam int Q_W       = 20;
    localparam int CNT_W     = 5;
    localparam int FF_W      = 41;

    // ports
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 152;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // fixed thresholds in raw q16.16 counts
    localparam int VALID_MIN    = 66;
    localparam int LIN_STEP_MIN = 6554;
    localparam int ANG_STEP_MIN = 19661;
    localparam int STOP_MAX     = 655;

    // register indexes
    localparam logic [2:0] REG_AXLE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [2:0] REG_MIN_SPEED   = 3'd2;
    localparam logic [2:0] REG_PPM         = 3'd3;
    localparam logic [2:0] REG_LIN_SLOPE   = 3'd4;
    localparam logic [2:0] REG_LIN_OFFSET  = 3'd5;
    localparam logic [2:0] REG_ANG_SLOPE   = 3'd6;
    localparam logic [2:0] REG_ANG_OFFSET  = 3'd7;

    // reset values
    localparam logic [SPD_W-1:0] AXLE_WIDTH_RST = 19'd16712;
    localparam logic [SPD_W-1:0] MAX_SPEED_RST  = 19'd52429;
    localparam logic [SPD_W-1:0] MIN_SPEED_RST  = 19'd0;
    localparam logic [PPM_W-1:0] PPM_RST        = 24'd244144;
    localparam logic [K_W-1:0]   LIN_SLOPE_RST  = 16'd28454;
    localparam logic [K_W-1:0]   LIN_OFFSET_RST = 16'd1840;
    localparam logic [K_W-1:0]   ANG_SLOPE_RST  = 16'd3480;
    localparam logic [K_W-1:0]   ANG_OFFSET_RST = 16'd3620;

    typedef struct packed {
        logic [SPD_W-1:0] axle_width;
        logic [SPD_W-1:0] max_wheel_speed;
        logic [SPD_W-1:0] min_wheel_speed;
        logic [PPM_W-1:0] pulses_per_meter;
        logic [K_W-1:0]   lin_ff_slope;
        logic [K_W-1:0]   lin_ff_offset;
        logic [K_W-1:0]   ang_ff_slope;
        logic [K_W-1:0]   ang_ff_offset;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_AXLE_W,
        MUL_LEFT_VMAX,
        MUL_RIGHT_VMAX,
        MUL_LEFT_PPM,
        MUL_RIGHT_PPM,
        MUL_LS_V,
        MUL_AS_W
    } mul_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_H,
        S_HALF,
        S_WHEEL,
        S_MAG,
        S_CHK,
        S_MUL_LS,
        S_DLOAD_L,
        S_DIV_L,
        S_WR_L,
        S_MUL_RS,
        S_DLOAD_R,
        S_DIV_R,
        S_WR_R,
        S_MIN,
        S_MUL_LP,
        S_MUL_RP,
        S_MUL_LF,
        S_MUL_AF,
        S_ANG,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     h_en;
        logic     wheel_en;
        logic     mag_en;
        logic     div_load;
        logic     div_step;
        logic     div_wr_l;
        logic     div_wr_r;
        logic     min_en;
        logic     lpr_en;
        logic     rpr_en;
        logic     lin_en;
        logic     ang_en;
        logic     sum_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic scale;
        logic div_last;
    } sts_t;

endpackage

// File: rtl/ddws_regs.sv
`timescale 1ns / 1ps
// configuration register file behind the apb port
module ddws_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ddws_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddws_pkg::DATA_W-1:0]  pwdata,
    output logic [ddws_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ddws_pkg::cfg_t               cfg
);

    ddws_pkg::cfg_t cfg_reg;
    ddws_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                ddws_pkg::REG_AXLE_WIDTH: cfg_next.axle_width       = pwdata[18:0];
                ddws_pkg::REG_MAX_SPEED:  cfg_next.max_wheel_speed  = pwdata[18:0];
                ddws_pkg::REG_MIN_SPEED:  cfg_next.min_wheel_speed  = pwdata[18:0];
                ddws_pkg::REG_PPM:        cfg_next.pulses_per_meter = pwdata[23:0];
                ddws_pkg::REG_LIN_SLOPE:  cfg_next.lin_ff_slope     = pwdata[15:0];
                ddws_pkg::REG_LIN_OFFSET: cfg_next.lin_ff_offset    = pwdata[15:0];
                ddws_pkg::REG_ANG_SLOPE:  cfg_next.ang_ff_slope     = pwdata[15:0];
                ddws_pkg::REG_ANG_OFFSET: cfg_next.ang_ff_offset    = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axle_width       <= ddws_pkg::AXLE_WIDTH_RST;
            cfg_reg.max_wheel_speed  <= ddws_pkg::MAX_SPEED_RST;
            cfg_reg.min_wheel_speed  <= ddws_pkg::MIN_SPEED_RST;
            cfg_reg.pulses_per_meter <= ddws_pkg::PPM_RST;
            cfg_reg.lin_ff_slope     <= ddws_pkg::LIN_SLOPE_RST;
            cfg_reg.lin_ff_offset    <= ddws_pkg::LIN_OFFSET_RST;
            cfg_reg.ang_ff_slope     <= ddws_pkg::ANG_SLOPE_RST;
            cfg_reg.ang_ff_offset    <= ddws_pkg::ANG_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            ddws_pkg::REG_AXLE_WIDTH: prdata = 32'(cfg_reg.axle_width);
            ddws_pkg::REG_MAX_SPEED:  prdata = 32'(cfg_reg.max_wheel_speed);
            ddws_pkg::REG_MIN_SPEED:  prdata = 32'(cfg_reg.min_wheel_speed);
            ddws_pkg::REG_PPM:        prdata = 32'(cfg_reg.pulses_per_meter);
            ddws_pkg::REG_LIN_SLOPE:  prdata = 32'(cfg_reg.lin_ff_slope);
            ddws_pkg::REG_LIN_OFFSET: prdata = 32'(cfg_reg.lin_ff_offset);
            ddws_pkg::REG_ANG_SLOPE:  prdata = 32'(cfg_reg.ang_ff_slope);
            ddws_pkg::REG_ANG_OFFSET: prdata = 32'(cfg_reg.ang_ff_offset);
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ddws_ctrl.sv
`timescale 1ns / 1ps
// sequencer that steps the shared multiplier and divider through one item
module ddws_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ddws_pkg::sts_t sts,
    output ddws_pkg::cmd_t cmd
);

    ddws_pkg::state_t state_reg;
    ddws_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddws_pkg::S_IDLE:    if (s_tvalid) state_next = ddws_pkg::S_MUL_H;
            ddws_pkg::S_MUL_H:   state_next = ddws_pkg::S_HALF;
            ddws_pkg::S_HALF:    state_next = ddws_pkg::S_WHEEL;
            ddws_pkg::S_WHEEL:   state_next = ddws_pkg::S_MAG;
            ddws_pkg::S_MAG:     state_next = ddws_pkg::S_CHK;
            ddws_pkg::S_CHK:     state_next = sts.scale ? ddws_pkg::S_MUL_LS : ddws_pkg::S_MIN;
            ddws_pkg::S_MUL_LS:  state_next = ddws_pkg::S_DLOAD_L;
            ddws_pkg::S_DLOAD_L: state_next = ddws_pkg::S_DIV_L;
            ddws_pkg::S_DIV_L:   if (sts.div_last) state_next = ddws_pkg::S_WR_L;
            ddws_pkg::S_WR_L:    state_next = ddws_pkg::S_MUL_RS;
            ddws_pkg::S_MUL_RS:  state_next = ddws_pkg::S_DLOAD_R;
            ddws_pkg::S_DLOAD_R: state_next = ddws_pkg::S_DIV_R;
            ddws_pkg::S_DIV_R:   if (sts.div_last) state_next = ddws_pkg::S_WR_R;
            ddws_pkg::S_WR_R:    state_next = ddws_pkg::S_MIN;
            ddws_pkg::S_MIN:     state_next = ddws_pkg::S_MUL_LP;
            ddws_pkg::S_MUL_LP:  state_next = ddws_pkg::S_MUL_RP;
            ddws_pkg::S_MUL_RP:  state_next = ddws_pkg::S_MUL_LF;
            ddws_pkg::S_MUL_LF:  state_next = ddws_pkg::S_MUL_AF;
            ddws_pkg::S_MUL_AF:  state_next = ddws_pkg::S_ANG;
            ddws_pkg::S_ANG:     state_next = ddws_pkg::S_SUM;
            ddws_pkg::S_SUM:     state_next = ddws_pkg::S_OUT;
            ddws_pkg::S_OUT:     if (out_free) state_next = ddws_pkg::S_IDLE;
            default:             state_next = ddws_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ddws_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ddws_pkg::S_MUL_H: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_AXLE_W;
            end
            ddws_pkg::S_HALF:    cmd.h_en = 1'b1;
            ddws_pkg::S_WHEEL:   cmd.wheel_en = 1'b1;
            ddws_pkg::S_MAG:     cmd.mag_en = 1'b1;
            ddws_pkg::S_MUL_LS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_LEFT_VMAX;
            end
            ddws_pkg::S_DLOAD_L: cmd.div_load = 1'b1;
            ddws_pkg::S_DIV_L:   cmd.div_step = 1'b1;
            ddws_pkg::S_WR_L:    cmd.div_wr_l = 1'b1;
            ddws_pkg::S_MUL_RS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_RIGHT_VMAX;
            end
            ddws_pkg::S_DLOAD_R: cmd.div_load = 1'b1;
            ddws_pkg::S_DIV_R:   cmd.div_step = 1'b1;
            ddws_pkg::S_WR_R:    cmd.div_wr_r = 1'b1;
            ddws_pkg::S_MIN:     cmd.min_en = 1'b1;
            ddws_pkg::S_MUL_LP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_LEFT_PPM;
            end
            // the multiply states from here on also retire the previous product
            ddws_pkg::S_MUL_RP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_RIGHT_PPM;
                cmd.lpr_en  = 1'b1;
            end
            ddws_pkg::S_MUL_LF: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_LS_V;
                cmd.rpr_en  = 1'b1;
            end
            ddws_pkg::S_MUL_AF: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ddws_pkg::MUL_AS_W;
                cmd.lin_en  = 1'b1;
            end
            ddws_pkg::S_ANG:     cmd.ang_en = 1'b1;
            ddws_pkg::S_SUM:     cmd.sum_en = 1'b1;
            ddws_pkg::S_OUT:     cmd.out_load = out_free;
            default:             cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ddws_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/ddws_dp.sv
`timescale 1ns / 1ps
// datapath: shared multiplier, serial divider, limits, feedforward, result register
module ddws_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ddws_pkg::cfg_t                     cfg,
    input  ddws_pkg::cmd_t                     cmd,
    output ddws_pkg::sts_t                     sts,
    input  logic [ddws_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic [ddws_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int WHL_W  = ddws_pkg::WHL_W;
    localparam int MAG_W  = ddws_pkg::MAG_W;
    localparam int PROD_W = ddws_pkg::PROD_W;
    localparam int DIV_W  = ddws_pkg::DIV_W;
    localparam int Q_W    = ddws_pkg::Q_W;
    localparam int CNT_W  = ddws_pkg::CNT_W;
    localparam int FF_W   = ddws_pkg::FF_W;
    localparam int DUTY_W = ddws_pkg::DUTY_W;
    localparam int RATE_W = ddws_pkg::RATE_W;

    // truncate toward zero from q16.16 and saturate
    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [FF_W-1:0] x);
        logic [FF_W-1:0]   xm;
        logic [FF_W-17:0]  m;
        logic [DUTY_W-1:0] d;
        xm = x[FF_W-1] ? -x : x;
        m  = xm[FF_W-1:16];
        if (!x[FF_W-1]) begin
            d = (m > (FF_W-16)'(21'h0FFFFF)) ? 21'h0FFFFF : m[DUTY_W-1:0];
        end else begin
            d = (m > (FF_W-16)'(22'h100000)) ? 21'h100000 : -m[DUTY_W-1:0];
        end
        return d;
    endfunction

    // input capture and pid reset test
    logic signed [19:0] v_in, v_reg, prev_v_reg;
    logic signed [21:0] w_in, w_reg, prev_w_reg;
    logic               lv_reg, av_reg, pidr_reg;
    logic               lv_next, av_next, pidr_next;
    logic signed [20:0] dv;
    logic signed [22:0] dw;
    logic [20:0]        dv_mag;
    logic [22:0]        dw_mag;
    logic [19:0]        v_mag;
    logic [21:0]        w_mag;

    assign v_in   = s_tdata[19:0];
    assign w_in   = s_tdata[41:20];
    assign dv     = 21'(prev_v_reg) - 21'(v_in);
    assign dw     = 23'(prev_w_reg) - 23'(w_in);
    assign dv_mag = dv[20] ? -dv : dv;
    assign dw_mag = dw[22] ? -dw : dw;
    assign v_mag  = v_in[19] ? -v_in : v_in;
    assign w_mag  = w_in[21] ? -w_in : w_in;

    assign pidr_next = (dv_mag >= 21'(ddws_pkg::LIN_STEP_MIN)) ||
                       (dw_mag >= 23'(ddws_pkg::ANG_STEP_MIN)) ||
                       ((v_mag <= 20'(ddws_pkg::STOP_MAX)) &&
                        (w_mag <= 22'(ddws_pkg::STOP_MAX)));
    assign lv_next = v_mag >= 20'(ddws_pkg::VALID_MIN);
    assign av_next = w_mag >= 22'(ddws_pkg::VALID_MIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_v_reg <= '0;
            prev_w_reg <= '0;
        end else if (cmd.load_in) begin
            prev_v_reg <= v_in;
            prev_w_reg <= w_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            v_reg    <= v_in;
            w_reg    <= w_in;
            lv_reg   <= lv_next;
            av_reg   <= av_next;
            pidr_reg <= pidr_next;
        end
    end

    // shared multiplier, signed by unsigned
    logic signed [WHL_W-1:0]              left_reg, right_reg, left_next, right_next;
    logic signed [ddws_pkg::MUL_A_W-1:0]  mul_a;
    logic [ddws_pkg::MUL_B_W-1:0]         mul_b;
    logic signed [ddws_pkg::MUL_B_W:0]    mul_b_s;
    logic signed [PROD_W-1:0]             prod_reg, prod_next;
    logic [PROD_W-1:0]                    prod_mag;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            ddws_pkg::MUL_AXLE_W: begin
                mul_a = ddws_pkg::MUL_A_W'(w_reg);
                mul_b = ddws_pkg::MUL_B_W'(cfg.axle_width);
            end
            ddws_pkg::MUL_LEFT_VMAX: begin
                mul_a = ddws_pkg::MUL_A_W'(left_reg);
                mul_b = ddws_pkg::MUL_B_W'(cfg.max_wheel_speed);
            end
            ddws_pkg::MUL_RIGHT_VMAX: begin
                mul_a = ddws_pkg::MUL_A_W'(right_reg);
                mul_b = ddws_pkg::MUL_B_W'(cfg.max_wheel_speed);
            end
            ddws_pkg::MUL_LEFT_PPM: begin
                mul_a = ddws_pkg::MUL_A_W'(left_reg);
                mul_b = cfg.pulses_per_meter;
            end
            ddws_pkg::MUL_RIGHT_PPM: begin
                mul_a = ddws_pkg::MUL_A_W'(right_reg);
                mul_b = cfg.pulses_per_meter;
            end
            ddws_pkg::MUL_LS_V: begin
                mul_a = ddws_pkg::MUL_A_W'(v_reg);
                mul_b = ddws_pkg::MUL_B_W'(cfg.lin_ff_slope);
            end
            ddws_pkg::MUL_AS_W: begin
                mul_a = ddws_pkg::MUL_A_W'(w_reg);
                mul_b = ddws_pkg::MUL_B_W'(cfg.ang_ff_slope);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_b_s   = $signed({1'b0, mul_b});
    assign prod_next = mul_a * mul_b_s;
    assign prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // half axle times w, rounded half away from zero
    logic [PROD_W-1:0]       h_sum;
    logic [MAG_W-1:0]        h_u;
    logic signed [WHL_W-1:0] h_reg, h_next;

    assign h_sum  = prod_mag + PROD_W'(65536);
    assign h_u    = h_sum[17 +: MAG_W];
    assign h_next = prod_reg[PROD_W-1] ? -$signed({1'b0, h_u}) : $signed({1'b0, h_u});

    always_ff @(posedge aclk) begin
        if (cmd.h_en) begin
            h_reg <= h_next;
        end
    end

    // wheel magnitudes and the larger one
    logic [WHL_W-1:0] lmag_w, rmag_w;
    logic [MAG_W-1:0] lmag, rmag, m_reg, m_next;

    assign lmag_w = left_reg[WHL_W-1] ? -left_reg : left_reg;
    assign rmag_w = right_reg[WHL_W-1] ? -right_reg : right_reg;
    assign lmag   = lmag_w[MAG_W-1:0];
    assign rmag   = rmag_w[MAG_W-1:0];
    assign m_next = (lmag > rmag) ? lmag : rmag;

    always_ff @(posedge aclk) begin
        if (cmd.mag_en) begin
            m_reg <= m_next;
        end
    end

    assign sts.scale = m_reg > MAG_W'(cfg.max_wheel_speed);

    // restoring divider, one quotient bit per cycle from the top
    logic [DIV_W-1:0]  rem_reg, rem_next, dsh_reg, dsh_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ge;
    logic signed [WHL_W-1:0] q_s;

    assign ge  = rem_reg >= dsh_reg;
    assign q_s = $signed(WHL_W'(q_reg));

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (cmd.div_load) begin
            // numerator 2*|s*vmax| + m, divisor 2*m aligned to the top quotient bit
            rem_next = {1'b0, prod_mag[DIV_W-3:0], 1'b0} + DIV_W'(m_reg);
            dsh_next = {m_reg, 1'b0, (Q_W-1)'(0)} & {DIV_W{1'b1}};
            q_next   = '0;
            cnt_next = CNT_W'(Q_W - 1);
        end else if (cmd.div_step) begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign sts.div_last = cnt_reg == '0;

    // wheel speed registers: difference and sum, scaled value, minimum cut
    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        if (cmd.wheel_en) begin
            left_next  = WHL_W'(v_reg) - h_reg;
            right_next = WHL_W'(v_reg) + h_reg;
        end else if (cmd.div_wr_l) begin
            left_next  = left_reg[WHL_W-1] ? -q_s : q_s;
        end else if (cmd.div_wr_r) begin
            right_next = right_reg[WHL_W-1] ? -q_s : q_s;
        end else if (cmd.min_en) begin
            if (lmag < MAG_W'(cfg.min_wheel_speed)) left_next = '0;
            if (rmag < MAG_W'(cfg.min_wheel_speed)) right_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // pulse rate, rounded half away from zero
    logic [PROD_W-1:0] r_sum;
    logic [RATE_W-1:0] rate_u, rate_next, lpr_reg, rpr_reg;

    assign r_sum     = prod_mag + PROD_W'(32768);
    assign rate_u    = r_sum[16 +: RATE_W];
    assign rate_next = prod_reg[PROD_W-1] ? -rate_u : rate_u;

    always_ff @(posedge aclk) begin
        if (cmd.lpr_en) lpr_reg <= rate_next;
        if (cmd.rpr_en) rpr_reg <= rate_next;
    end

    // feedforward terms in q16.16
    logic              lin_only, ang_only;
    logic [FF_W-1:0]   lo_off, ao_off;
    logic signed [FF_W-1:0] prod_ff, lin_term, ang_term;
    logic signed [FF_W-1:0] ffa_reg, ffa_next, ffb_reg, ffb_next;

    assign lin_only = lv_reg && !av_reg;
    assign ang_only = !lv_reg && av_reg;
    assign prod_ff  = FF_W'(prod_reg);
    // full offset when only one command is valid, otherwise half
    assign lo_off   = lin_only ? FF_W'({cfg.lin_ff_offset, 16'h0000})
                               : FF_W'({cfg.lin_ff_offset, 15'h0000});
    assign ao_off   = ang_only ? FF_W'({cfg.ang_ff_offset, 16'h0000})
                               : FF_W'({cfg.ang_ff_offset, 15'h0000});

    always_comb begin
        lin_term = prod_ff;
        if (v_reg < 0) begin
            lin_term = prod_ff - $signed(lo_off);
        end else if (v_reg != 0) begin
            lin_term = prod_ff + $signed(lo_off);
        end
        ang_term = prod_ff;
        if (w_reg < 0) begin
            ang_term = prod_ff - $signed(ao_off);
        end else if (w_reg != 0) begin
            ang_term = prod_ff + $signed(ao_off);
        end
    end

    always_comb begin
        ffa_next = ffa_reg;
        ffb_next = ffb_reg;
        if (cmd.lin_en) begin
            ffa_next = ang_only ? '0 : lin_term;
        end else if (cmd.ang_en) begin
            ffb_next = lin_only ? '0 : ang_term;
        end else if (cmd.sum_en) begin
            ffa_next = ffa_reg - ffb_reg;
            ffb_next = ffa_reg + ffb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ffa_reg <= ffa_next;
        ffb_reg <= ffb_next;
    end

    // result register
    logic [ddws_pkg::OUT_TDATA_W-1:0] out_reg, out_next;

    assign out_next = {1'b0, pidr_reg, sat_duty(ffb_reg), sat_duty(ffa_reg),
                       rpr_reg, lpr_reg,
                       right_reg[ddws_pkg::OSPD_W-1:0], left_reg[ddws_pkg::OSPD_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: rtl/diff_drive_wheel_setpoint.sv
`timescale 1ns / 1ps
// Differential drive wheel setpoint: velocity command in, wheel speeds,
// encoder pulse rates, feedforward duties and a pid reset flag out.
//
// s_ channel: one item holds a linear and an angular velocity in q16.16.
// m_ channel: one result item per input item, in the same order.
// apb port: eight configuration registers at byte addresses 0, 4 .. 28;
// write them only while no item is in flight.
//
// When neither wheel exceeds the speed limit the serial divider is skipped;
// when one does, two extra passes run the divider, one per wheel, which
// sets the worst case. One item is worked on at a time; s_tready is high
// only between items, and the next item is taken while the previous result
// still waits in the output register.
//
// Reset clears the sequencer, the output valid, the stored previous command
// and loads the default register values. When the receiver stalls, the
// finished item waits in the output stage and the block holds its next result
// until the output register is free.
module diff_drive_wheel_setpoint (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [19:0] lin_vel, [41:20] ang_vel, [47:42] zero
    input  logic [ddws_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [21:0] left_speed, [43:22] right_speed, [75:44] left_pulse_rate,
    // [107:76] right_pulse_rate, [128:108] left_ff_duty,
    // [149:129] right_ff_duty, [150] pid_reset, [151] zero
    output logic [ddws_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ddws_pkg::ADDR_W-1:0]         paddr,
    input  logic [ddws_pkg::DATA_W-1:0]         pwdata,
    output logic [ddws_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    ddws_pkg::cfg_t cfg;
    ddws_pkg::cmd_t cmd;
    ddws_pkg::sts_t sts;

    ddws_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddws_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// File: rtl/ddws_chk.sv
`timescale 1ns / 1ps
// port-level checks for the wheel setpoint block, bound to the top level
module ddws_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [ddws_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ddws_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [ddws_pkg::ADDR_W-1:0]        paddr,
    input logic [ddws_pkg::DATA_W-1:0]        pwdata,
    input logic [ddws_pkg::DATA_W-1:0]        prdata,
    input logic                               pready
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: the sequencer leaves idle on accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("second item taken while one is in flight");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

    // limited wheel speeds never exceed the 19 bit register range
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:19] == 3'b000 || m_tdata[21:19] == 3'b111) &&
                     (m_tdata[43:41] == 3'b000 || m_tdata[43:41] == 3'b111))
        else $error("wheel speed outside limit range");

endmodule

bind diff_drive_wheel_setpoint ddws_chk u_ddws_chk (.*);
